// File: hdl/socd_pkg.sv
package socd_pkg;

	localparam int KEY_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		ACT_PASS    = 2'd0,
		ACT_PRESS   = 2'd1,
		ACT_RELEASE = 2'd2
	} action_t;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE = 3'd4;

	localparam key_t LEFT_RST   = 16'd4;
	localparam key_t RIGHT_RST  = 16'd7;
	localparam key_t UP_RST     = 16'd26;
	localparam key_t DOWN_RST   = 16'd22;
	localparam key_t TOGGLE_RST = 16'd104;

	typedef struct packed {
		action_t action;
		key_t    code;
		logic    last;
	} res_t;

endpackage

// File: hdl/socd_in_if.sv
interface socd_in_if import socd_pkg::*; ();
	logic valid;
	logic ready;
	key_t key_code;
	logic key_pressed;

	modport source(output valid, output key_code, output key_pressed, input ready);
	modport sink(input valid, input key_code, input key_pressed, output ready);
endinterface

// File: hdl/socd_out_if.sv
interface socd_out_if import socd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] action;
	key_t       out_code;
	logic       last;

	modport source(output valid, output action, output out_code, output last, input ready);
	modport sink(input valid, input action, input out_code, input last, output ready);
endinterface

// File: hdl/socd_last_input_cleaner.sv
// flow: an accepted key event is held in the input register and moves on into the
//   result register pair once that has room; only then is its result offered
// throughput: one event per cycle while each event makes at most one result and
//   the output is ready; an event that makes two results holds the pipe until
//   both have been taken from the result register pair
// reset: pair state cleared, cleaning off, key registers back to their defaults
module socd_last_input_cleaner import socd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  key_t                 cfg_data,
	socd_in_if.sink              in_ch,
	socd_out_if.source           out_ch
);

	key_t left_q, right_q, up_q, down_q, toggle_q;

	logic [3:0] held_q, rep_q;
	logic       cleaning_q;

	logic valid_s1;
	key_t code_s1;
	logic pressed_s1;

	res_t       res0_q, res1_q;
	logic [1:0] cnt_q;

	logic       in_take, out_take, room, s1_fire;
	logic       is_tog, hit;
	logic [1:0] slot;
	logic [3:0] me, other, held_d, rep_d, rep_mid;
	logic       clean_d;
	logic       e1, e2;
	res_t       ev1, ev2, r0, r1;
	logic [1:0] n_c;

	function automatic key_t pick_code(input logic [1:0] s, input key_t l, input key_t r,
			input key_t u, input key_t d);
		case (s)
			2'd0:    pick_code = l;
			2'd1:    pick_code = r;
			2'd2:    pick_code = u;
			default: pick_code = d;
		endcase
	endfunction

	assign in_take  = in_ch.valid && in_ch.ready;
	assign out_take = out_ch.valid && out_ch.ready;
	// the pair buffer must be empty by the next edge before a new request moves in
	assign room     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_take);
	assign s1_fire  = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || s1_fire;

	assign out_ch.valid    = (cnt_q != 2'd0);
	assign out_ch.action   = res0_q.action;
	assign out_ch.out_code = res0_q.code;
	assign out_ch.last     = res0_q.last;

	always_comb begin
		is_tog = (code_s1 == toggle_q);
		hit  = 1'b1;
		slot = 2'd0;
		if (code_s1 == left_q) begin
			slot = 2'd0;
		end else if (code_s1 == right_q) begin
			slot = 2'd1;
		end else if (code_s1 == up_q) begin
			slot = 2'd2;
		end else if (code_s1 == down_q) begin
			slot = 2'd3;
		end else begin
			hit = 1'b0;
		end
		me    = 4'b0001 << slot;
		other = 4'b0001 << (slot ^ 2'd1);

		held_d  = held_q;
		rep_d   = rep_q;
		rep_mid = rep_q;
		clean_d = cleaning_q;
		e1  = 1'b0;
		e2  = 1'b0;
		ev1 = '{action: ACT_RELEASE, code: pick_code(slot ^ 2'd1, left_q, right_q, up_q,
			down_q), last: 1'b0};
		ev2 = '{action: ACT_PRESS, code: pick_code(slot, left_q, right_q, up_q, down_q),
			last: 1'b0};
		r0  = '{action: ACT_PASS, code: code_s1, last: 1'b1};
		r1  = r0;
		n_c = 2'd0;

		if (is_tog) begin
			if (pressed_s1) begin
				clean_d = !cleaning_q;
			end
		end else if (cleaning_q && hit) begin
			if (pressed_s1) begin
				held_d = held_q | me;
				e1 = |(rep_q & other);
				e2 = !(|(rep_q & me));
				rep_d = (rep_q & ~other) | me;
			end else begin
				held_d  = held_q & ~me;
				e1      = |(rep_q & me);
				rep_mid = rep_q & ~me;
				// opposite key comes back if still held and not reported
				e2      = |(held_d & other) && !(|(rep_mid & other));
				rep_d   = rep_mid | (e2 ? other : 4'b0000);
				ev1.code = pick_code(slot, left_q, right_q, up_q, down_q);
				ev2.code = pick_code(slot ^ 2'd1, left_q, right_q, up_q, down_q);
			end
			if (e1 && e2) begin
				r0 = ev1;
				r1 = ev2;
				r1.last = 1'b1;
				n_c = 2'd2;
			end else if (e1) begin
				r0 = ev1;
				r0.last = 1'b1;
				n_c = 2'd1;
			end else if (e2) begin
				r0 = ev2;
				r0.last = 1'b1;
				n_c = 2'd1;
			end
		end else begin
			n_c = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= LEFT_RST;
			right_q    <= RIGHT_RST;
			up_q       <= UP_RST;
			down_q     <= DOWN_RST;
			toggle_q   <= TOGGLE_RST;
			held_q     <= 4'b0000;
			rep_q      <= 4'b0000;
			cleaning_q <= 1'b0;
			valid_s1   <= 1'b0;
			cnt_q      <= 2'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEFT:   left_q   <= cfg_data;
					CFG_RIGHT:  right_q  <= cfg_data;
					CFG_UP:     up_q     <= cfg_data;
					CFG_DOWN:   down_q   <= cfg_data;
					CFG_TOGGLE: toggle_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				held_q     <= held_d;
				rep_q      <= rep_d;
				cleaning_q <= clean_d;
				cnt_q      <= n_c;
			end else if (out_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1    <= in_ch.key_code;
			pressed_s1 <= in_ch.key_pressed;
		end
		if (s1_fire) begin
			res0_q <= r0;
			res1_q <= r1;
		end else if (out_take) begin
			res0_q <= res1_q;
		end
	end

	// at most one key of each pair is ever reported down
	a_pair_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rep_q[0] && rep_q[1]) && !(rep_q[2] && rep_q[3]))
		else $error("both keys of a pair reported down");

	// a key is only reported down while physically held
	a_rep_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_q & ~held_q) == 4'b0000)
		else $error("reported key not held");

	a_two_first: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !res0_q.last && res1_q.last)
		else $error("last flag misplaced in full buffer");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> res0_q.last)
		else $error("single pending result without last");

	a_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_tog && pressed_s1 |=> cleaning_q != $past(cleaning_q))
		else $error("toggle press did not flip cleaning");

endmodule
